// ----- rtl/twa_pkg.sv -----
package twa_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int WORKER_W    = $clog2(MAX_WORKERS);
    localparam int NWORK_W     = WORKER_W + 1;
    localparam int LOAD_W      = 40;
    localparam int WEIGHT_W    = 32;
    localparam int COUNT_W     = 32;
    localparam int STEP_W      = $clog2(COUNT_W);
    localparam int MODE_W      = 2;
    localparam int REG_IDX_W   = 1;
    localparam int CFG_W       = 5;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 8;

    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

    localparam logic [MODE_W-1:0] MODE_DYNAMIC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STATIC   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BALANCED = 2'd2;

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_WAIT   = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_SCHEDULE_MODE  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_WORKERS = 1'd1;

    localparam logic [CFG_W-1:0] WORKERS_RESET = CFG_W'(MAX_WORKERS);

    typedef struct packed {
        logic                en;
        logic [WORKER_W-1:0] idx;
        logic [LOAD_W-1:0]   data;
    } load_wr_t;

    typedef struct packed {
        logic [LOAD_W-1:0] diff;
        logic              lt;
    } alu_res_t;

endpackage

// ----- rtl/task_worker_assigner.sv -----
// sequence from the accepting edge to the result in the output reg: wait, rejected or
//   dynamic requests go straight to done, static runs a bit-serial remainder (one bit a
//   cycle over 32 bits) then done, balanced scans n active workers (one load compared
//   per cycle), then updates the load, then done; one request at a time, the next is
//   taken once the result is in the output reg
// reset: loads and submit counter cleared, schedule_mode 0, active_workers 16
module task_worker_assigner
    import twa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [0] has_function, [32:1] task_weight, rest zero
    input  logic                 s_tuser,   // [0] command
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata    // [0] status, [1] is_targeted,
                                            // [5:2] worker_index, rest zero
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [CFG_W-1:0]    workers_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  dividend_reg, dividend_next;
    logic [WORKER_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [WORKER_W-1:0] idx_reg, idx_next;
    logic [LOAD_W-1:0]   best_reg, best_next;
    logic [WORKER_W-1:0] target_reg, target_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [NWORK_W-1:0]  nwork_reg, nwork_next;
    logic                res_status_reg, res_status_next;
    logic                res_tgt_reg, res_tgt_next;
    logic [WORKER_W-1:0] res_idx_reg, res_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic                accept;
    logic                in_cmd;
    logic                in_has_fn;
    logic [WEIGHT_W-1:0] in_weight;
    logic [NWORK_W-1:0]  nwork_eff;
    logic [NWORK_W-1:0]  rem_shift;
    logic [LOAD_W-1:0]   alu_a, alu_b;
    alu_res_t            alu_res;
    logic [LOAD_W-1:0]   load_rd;
    logic                load_clear;
    load_wr_t            load_wr;
    logic [LOAD_W:0]     sat_sum;

    assign accept    = s_tvalid && s_tready;
    assign in_cmd    = s_tuser;
    assign in_has_fn = s_tdata[0];
    assign in_weight = s_tdata[WEIGHT_W:1];
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // zero workers means one, anything above the pool size means the whole pool
    always_comb
    begin
        priority if (workers_reg == '0)
        begin
            nwork_eff = NWORK_W'(1);
        end
        else if (workers_reg > CFG_W'(MAX_WORKERS))
        begin
            nwork_eff = NWORK_W'(MAX_WORKERS);
        end
        else
        begin
            nwork_eff = NWORK_W'(workers_reg);
        end
    end

    // next partial remainder before the trial subtract
    assign rem_shift = {rem_reg, dividend_reg[COUNT_W-1]};

    // shared compare/subtract unit operand select
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            alu_a = load_rd;
            alu_b = best_reg;
        end
        else
        begin
            alu_a = LOAD_W'(rem_shift);
            alu_b = LOAD_W'(nwork_reg);
        end
    end

    twa_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // saturating load update, carry out means past the top
    assign sat_sum = {1'b0, best_reg} + {{(LOAD_W+1-WEIGHT_W){1'b0}}, weight_reg};

    always_comb
    begin
        load_wr.en   = (state_reg == ST_UPD);
        load_wr.idx  = target_reg;
        load_wr.data = sat_sum[LOAD_W] ? LOAD_MAX : sat_sum[LOAD_W-1:0];
    end

    assign load_clear = accept && (in_cmd == CMD_WAIT);

    twa_load_bank u_load_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (load_clear),
        .rd_idx  (idx_reg),
        .rd_data (load_rd),
        .wr      (load_wr)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        dividend_next   = dividend_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        idx_next        = idx_reg;
        best_next       = best_reg;
        target_next     = target_reg;
        weight_next     = weight_reg;
        nwork_next      = nwork_reg;
        res_status_next = res_status_reg;
        res_tgt_next    = res_tgt_reg;
        res_idx_next    = res_idx_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    weight_next     = in_weight;
                    nwork_next      = nwork_eff;
                    res_status_next = STATUS_OK;
                    res_tgt_next    = 1'b0;
                    res_idx_next    = '0;
                    state_next      = ST_DONE;
                    if (in_cmd == CMD_WAIT)
                    begin
                        count_next = '0;
                    end
                    else if (!in_has_fn || (in_weight == '0))
                    begin
                        res_status_next = STATUS_REJECTED;
                    end
                    else if (mode_reg == MODE_STATIC)
                    begin
                        dividend_next = count_reg;
                        rem_next      = '0;
                        step_next     = STEP_W'(COUNT_W - 1);
                        state_next    = ST_DIV;
                    end
                    else if (mode_reg == MODE_BALANCED)
                    begin
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        // dynamic, and the unused mode code acts the same
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
            end
            ST_DIV:
            begin
                // restoring remainder, one dividend bit per cycle
                rem_next      = alu_res.lt ? rem_shift[WORKER_W-1:0]
                                           : alu_res.diff[WORKER_W-1:0];
                dividend_next = {dividend_reg[COUNT_W-2:0], 1'b0};
                step_next     = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    res_tgt_next = 1'b1;
                    res_idx_next = rem_next;
                    count_next   = count_reg + COUNT_W'(1);
                    state_next   = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                // strict less-than keeps the lowest index on ties
                if ((idx_reg == '0) || alu_res.lt)
                begin
                    best_next   = load_rd;
                    target_next = idx_reg;
                end
                if ({1'b0, idx_reg} == (nwork_reg - NWORK_W'(1)))
                begin
                    state_next = ST_UPD;
                end
                else
                begin
                    idx_next = idx_reg + WORKER_W'(1);
                end
            end
            ST_UPD:
            begin
                res_tgt_next = 1'b1;
                res_idx_next = target_reg;
                count_next   = count_reg + COUNT_W'(1);
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // hand the result over once the output reg is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(M_DATA_W-2-WORKER_W){1'b0}},
                                      res_idx_reg, res_tgt_reg, res_status_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_DYNAMIC;
            workers_reg   <= WORKERS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_SCHEDULE_MODE:  mode_reg    <= cfg_wdata[MODE_W-1:0];
                    REG_ACTIVE_WORKERS: workers_reg <= cfg_wdata;
                    default:            ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dividend_reg   <= dividend_next;
        rem_reg        <= rem_next;
        step_reg       <= step_next;
        idx_reg        <= idx_next;
        best_reg       <= best_next;
        target_reg     <= target_next;
        weight_reg     <= weight_next;
        nwork_reg      <= nwork_next;
        res_status_reg <= res_status_next;
        res_tgt_reg    <= res_tgt_next;
        res_idx_reg    <= res_idx_next;
        out_data_reg   <= out_data_next;
    end

endmodule

// ----- rtl/twa_alu.sv -----
module twa_alu
    import twa_pkg::*;
(
    input  logic [LOAD_W-1:0] a,
    input  logic [LOAD_W-1:0] b,
    output alu_res_t          res
);

    logic [LOAD_W:0] sub;

    // one wide subtract; the borrow doubles as the less-than flag
    assign sub      = {1'b0, a} - {1'b0, b};
    assign res.diff = sub[LOAD_W-1:0];
    assign res.lt   = sub[LOAD_W];

endmodule

// ----- rtl/twa_load_bank.sv -----
module twa_load_bank
    import twa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic [WORKER_W-1:0] rd_idx,
    output logic [LOAD_W-1:0]   rd_data,
    input  load_wr_t            wr
);

    logic [LOAD_W-1:0]      load_reg [MAX_WORKERS];
    logic [MAX_WORKERS-1:0] valid_reg;
    logic [MAX_WORKERS-1:0] valid_next;

    // an entry without its valid bit reads as zero load
    assign rd_data = valid_reg[rd_idx] ? load_reg[rd_idx] : '0;

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr.en)
        begin
            valid_next[wr.idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && !clear)
        begin
            load_reg[wr.idx] <= wr.data;
        end
    end

endmodule

// ----- verif/task_worker_assigner_tb.sv -----
module task_worker_assigner_tb;
    import twa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // mode code that the block does not define, must act as dynamic
    localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;
    localparam int                CYCLE_LIMIT    = 500000;

    typedef struct {
        logic                cmd;
        logic                has_function;
        logic [WEIGHT_W-1:0] weight;
    } request_t;

    typedef struct {
        logic                status;
        logic                is_targeted;
        logic [WORKER_W-1:0] worker_index;
    } assignment_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;   // [0] has_function, [32:1] task_weight, rest zero
    logic                 s_tuser = 1'b0; // [0] command
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;        // [0] status, [1] is_targeted, [5:2] worker_index

    // request queue feeding the driver, assignments still owed by the block
    request_t    pending_requests[$];
    assignment_t expected_assignments[$];
    request_t    driven_req;

    // shadow copy of the block state and registers
    logic [LOAD_W-1:0]  load_shadow[MAX_WORKERS];
    logic [COUNT_W-1:0] submit_shadow;
    logic [MODE_W-1:0]  mode_shadow;
    logic [CFG_W-1:0]   workers_shadow;

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          calm = 1'b0;   // no idling on either side while set

    task_worker_assigner u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // global watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void clear_loads();
        for (int i = 0; i < MAX_WORKERS; i++)
            load_shadow[i] = '0;
        submit_shadow = '0;
    endfunction

    // works out the assignment for one request and advances the shadow state
    function automatic assignment_t assign_worker(request_t req);
        assignment_t       res;
        int                n;
        int                pick;
        logic [LOAD_W-1:0] best;
        logic [LOAD_W:0]   sum;
        res = '{STATUS_OK, 1'b0, '0};
        pick = 0;
        if (req.cmd == CMD_WAIT)
        begin
            clear_loads();
            return res;
        end
        if (!req.has_function || req.weight == '0)
        begin
            res.status = STATUS_REJECTED;
            return res;
        end
        // zero workers acts as one, anything above the maximum is clamped
        n = int'(workers_shadow);
        if (n == 0)
            n = 1;
        if (n > MAX_WORKERS)
            n = MAX_WORKERS;
        if (mode_shadow == MODE_STATIC)
        begin
            pick = int'(submit_shadow % COUNT_W'(n));
            res.is_targeted = 1'b1;
        end
        else if (mode_shadow == MODE_BALANCED)
        begin
            // least loaded worker, lowest index wins a tie
            best = load_shadow[0];
            for (int i = 1; i < n; i++)
            begin
                if (load_shadow[i] < best)
                begin
                    best = load_shadow[i];
                    pick = i;
                end
            end
            sum = {1'b0, load_shadow[pick]} + (LOAD_W + 1)'(req.weight);
            load_shadow[pick] = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
            res.is_targeted = 1'b1;
        end
        // dynamic and undefined modes leave the task unbound
        submit_shadow = submit_shadow + 1'b1;
        if (res.is_targeted)
            res.worker_index = WORKER_W'(pick);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // driver: next request from the queue, random gaps between requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_assignments.push_back(assign_worker(driven_req));
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 30))
                begin
                    driven_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, driven_req.weight, driven_req.has_function};
                    s_tuser  <= driven_req.cmd;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure, every result checked against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        assignment_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_assignments.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result 0x%02h", m_tdata));
                end
                else
                begin
                    want = expected_assignments.pop_front();
                    if (m_tdata[0] !== want.status)
                        report_mismatch($sformatf("status %b, want %b",
                                                  m_tdata[0], want.status));
                    if (m_tdata[1] !== want.is_targeted)
                        report_mismatch($sformatf("is_targeted %b, want %b",
                                                  m_tdata[1], want.is_targeted));
                    if (m_tdata[5:2] !== want.worker_index)
                        report_mismatch($sformatf("worker_index %0d, want %0d",
                                                  m_tdata[5:2], want.worker_index));
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 30);
        end
    end

    // wait until the block holds nothing and owes nothing
    task automatic drain();
        while (pending_requests.size() > 0 || s_tvalid || expected_assignments.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_SCHEDULE_MODE)
            mode_shadow = value[MODE_W-1:0];
        else
            workers_shadow = value;
        @(negedge clk);
    endtask

    task automatic configure(logic [MODE_W-1:0] mode, logic [CFG_W-1:0] workers);
        drain();
        write_reg(REG_SCHEDULE_MODE, CFG_W'(mode));
        write_reg(REG_ACTIVE_WORKERS, workers);
    endtask

    task automatic send(logic cmd, logic has_function, logic [WEIGHT_W-1:0] weight);
        request_t req;
        req = '{cmd, has_function, weight};
        pending_requests.push_back(req);
    endtask

    // mostly small weights so balanced mode sees ties, heavy pushes loads to saturation
    task automatic random_phase(logic [MODE_W-1:0] mode, logic [CFG_W-1:0] workers,
                                int count, int wait_pct, bit heavy);
        logic                cmd;
        logic                has_function;
        logic [WEIGHT_W-1:0] weight;
        configure(mode, workers);
        calm = heavy;
        for (int k = 0; k < count; k++)
        begin
            cmd          = ($urandom_range(99) < wait_pct) ? CMD_WAIT : CMD_SUBMIT;
            has_function = ($urandom_range(99) < 92);
            if (heavy)
                weight = ($urandom_range(99) < 95) ? '1 : $urandom;
            else
            begin
                case ($urandom_range(9))
                    0:       weight = '0;
                    1:       weight = '1;
                    2, 3:    weight = $urandom;
                    default: weight = $urandom_range(20, 1);
                endcase
            end
            send(cmd, has_function, weight);
        end
    endtask

    initial
    begin
        clear_loads();
        mode_shadow    = MODE_DYNAMIC;
        workers_shadow = WORKERS_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, dynamic: unbound tasks, both reject causes, wait with junk fields
        send(CMD_SUBMIT, 1'b1, 32'd1);
        send(CMD_SUBMIT, 1'b1, '1);
        send(CMD_SUBMIT, 1'b0, 32'd5);
        send(CMD_SUBMIT, 1'b1, '0);
        send(CMD_WAIT, 1'b1, '1);

        // static round robin over three workers, wait restarts the count
        configure(MODE_STATIC, 5'd3);
        for (int k = 0; k < 5; k++)
            send(CMD_SUBMIT, 1'b1, 32'(k + 1));
        send(CMD_SUBMIT, 1'b0, '0);
        send(CMD_WAIT, 1'b0, '0);
        send(CMD_SUBMIT, 1'b1, 32'd9);

        // balanced over four workers: ties, lowest index, large weight
        configure(MODE_BALANCED, 5'd4);
        send(CMD_SUBMIT, 1'b1, 32'd10);
        send(CMD_SUBMIT, 1'b1, 32'd1);
        send(CMD_SUBMIT, 1'b1, 32'd1);
        send(CMD_SUBMIT, 1'b1, '1);
        send(CMD_SUBMIT, 1'b1, 32'd3);
        send(CMD_WAIT, 1'b1, 32'd7);
        send(CMD_SUBMIT, 1'b1, 32'd2);

        // undefined mode with zero workers, then worker count above the maximum
        configure(MODE_UNDEFINED, 5'd0);
        send(CMD_SUBMIT, 1'b1, 32'd7);
        send(CMD_SUBMIT, 1'b0, 32'd7);
        configure(MODE_STATIC, 5'd31);
        for (int k = 0; k < 3; k++)
            send(CMD_SUBMIT, 1'b1, 32'h8000_0000);

        random_phase(MODE_STATIC,    5'd16, 100, 4, 1'b0);
        random_phase(MODE_BALANCED,  5'd16, 150, 4, 1'b0);
        // single worker, back to back max weights with no idling: load saturates
        random_phase(MODE_BALANCED,  5'd1,  300, 0, 1'b1);
        random_phase(MODE_DYNAMIC,   5'd16,  60, 5, 1'b0);
        random_phase(MODE_STATIC,    5'd7,   80, 3, 1'b0);
        random_phase(MODE_BALANCED,  5'd5,  120, 3, 1'b0);
        random_phase(MODE_UNDEFINED, 5'd0,   40, 5, 1'b0);
        random_phase(MODE_STATIC,    5'd1,   40, 5, 1'b0);
        random_phase(MODE_BALANCED,  5'd31,  60, 3, 1'b0);

        drain();
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
